// ===== sv/task_trace_record_table_core_macros.svh =====
// Assertion macros for the task trace record table.
// Included by the controller and datapath modules; expects clk and rst_n in scope.
`ifndef TASK_TRACE_RECORD_TABLE_CORE_MACROS_SVH
`define TASK_TRACE_RECORD_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ttr_pkg.sv =====
// Package for the task trace record table: table geometry, operation codes,
// entry record type, controller command type and nibble keep masks. No dependencies.
`default_nettype none

package ttr_pkg;

  localparam int ENTRIES = 1024;
  localparam int ADDR_W  = $clog2(ENTRIES);

  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_RECORD = 3'd1;
  localparam logic [2:0] FN_SW_GO  = 3'd2;
  localparam logic [2:0] FN_SW_END = 3'd3;
  localparam logic [2:0] FN_COUNT  = 3'd4;
  localparam logic [2:0] FN_READ   = 3'd5;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [9:0]  task_id;
    logic [31:0] state_word;
    logic [15:0] block_number;
    logic [31:0] start_time;
    logic [31:0] elapsed_time;
    logic [31:0] max_elapsed;
    logic [31:0] event_count;
    logic [31:0] stopwatch;
  } entry_t;

  typedef struct packed {
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              capture;
    logic              exec;
  } cmd_t;

  // Bits kept when one nibble is replaced; select 1 is the top nibble.
  function automatic logic [31:0] keep_mask(input logic [3:0] sel);
    logic [31:0] m;
    case (sel)
      4'd1:    m = 32'h0fff_ffff;
      4'd2:    m = 32'hf0ff_ffff;
      4'd3:    m = 32'hff0f_ffff;
      4'd4:    m = 32'hfff0_ffff;
      4'd5:    m = 32'hffff_0fff;
      4'd6:    m = 32'hffff_f0ff;
      4'd7:    m = 32'hffff_ff0f;
      4'd8:    m = 32'hffff_fff0;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ttr_ctrl.sv =====
// Controller for the task trace record table: post-reset clearing sweep,
// accept and execute sequencing. Depends on ttr_pkg and the macros header.
`default_nettype none
`include "task_trace_record_table_core_macros.svh"

module ttr_ctrl
  import ttr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output cmd_t      cmd
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    busy         = 1'b1;
    cmd          = '0;
    cmd.clr_addr = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we   = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `TTR_ASSERT_NEXT(a_capture_then_exec, cmd.capture, cmd.exec, "capture not followed by exec")
  `TTR_ASSERT_NEXT(a_exec_single, cmd.exec, !cmd.exec && !busy, "exec lasted more than a cycle")
  `TTR_ASSERT_NOW(a_no_accept_in_sweep, cmd.clr_we, busy && !cmd.capture, "accept during clear")

endmodule

`default_nettype wire

// ===== sv/ttr_dpath.sv =====
// Datapath for the task trace record table: entry memory, read-modify-write
// of one record and registered result. Depends on ttr_pkg and the macros header.
`default_nettype none
`include "task_trace_record_table_core_macros.svh"

module ttr_dpath
  import ttr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [2:0]  in_func,
  input  wire logic [9:0]  in_entry_index,
  input  wire logic [15:0] in_block_number,
  input  wire logic [31:0] in_state_bits,
  input  wire logic [3:0]  in_nibble_select,
  input  wire logic [31:0] in_timestamp,
  output logic             out_strobe,
  output logic             out_valid_out,
  output logic [9:0]       out_task_id,
  output logic [31:0]      out_state_word,
  output logic [15:0]      out_block_number_out,
  output logic [31:0]      out_elapsed_time,
  output logic [31:0]      out_max_elapsed,
  output logic [31:0]      out_event_count,
  output logic [31:0]      out_stopwatch
);

  entry_t mem [ENTRIES];

  logic [2:0]  func_r;
  logic [9:0]  idx_r;
  logic [15:0] blk_r;
  logic [31:0] bits_r;
  logic [3:0]  sel_r;
  logic [31:0] ts_r;
  logic        in_range_r;
  entry_t      rdata_r;

  entry_t      upd;
  entry_t      res_view;
  logic        vout;
  logic [31:0] el;
  logic        we;
  logic [ADDR_W-1:0] waddr;
  entry_t      wdata;

  logic        strobe_r;
  entry_t      res_r;

  // Latch the item and read its entry.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_func;
      idx_r      <= in_entry_index;
      blk_r      <= in_block_number;
      bits_r     <= in_state_bits;
      sel_r      <= in_nibble_select;
      ts_r       <= in_timestamp;
      in_range_r <= (32'(in_entry_index) < 32'(ENTRIES));
      rdata_r    <= mem[ADDR_W'(in_entry_index)];
    end
  end

  always_comb begin
    upd  = rdata_r;
    vout = rdata_r.valid;
    el   = ts_r - rdata_r.start_time;
    case (func_r)
      FN_CLEAR: begin
        upd.valid        = 1'b0;
        upd.task_id      = '0;
        upd.state_word   = '0;
        upd.block_number = '0;
        upd.max_elapsed  = '0;
        upd.event_count  = '0;
        upd.start_time   = ts_r;
        upd.stopwatch    = '0;
        vout             = 1'b0;
      end
      FN_RECORD: begin
        upd.valid        = 1'b1;
        upd.task_id      = idx_r;
        upd.block_number = blk_r;
        upd.elapsed_time = el;
        if (el > rdata_r.max_elapsed) begin
          upd.max_elapsed = el;
        end
        if (sel_r inside {[4'd1:4'd8]}) begin
          upd.state_word = (rdata_r.state_word & keep_mask(sel_r)) | bits_r;
        end else begin
          upd.state_word = '0;
        end
        vout = 1'b1;
      end
      FN_SW_GO:  upd.stopwatch   = ts_r;
      FN_SW_END: upd.stopwatch   = ts_r - rdata_r.stopwatch;
      FN_COUNT:  upd.event_count = rdata_r.event_count + 32'd1;
      FN_READ:   upd.valid       = 1'b0;
      default: begin
      end
    endcase
    // Result shows the valid bit as it was before a release.
    res_view       = upd;
    res_view.valid = vout;
  end

  // Single write port shared by the clearing sweep and write-back.
  always_comb begin
    we    = cmd.clr_we || (cmd.exec && in_range_r);
    waddr = cmd.clr_we ? cmd.clr_addr : ADDR_W'(idx_r);
    wdata = cmd.clr_we ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= in_range_r ? res_view : '0;
    end
  end

  assign out_strobe           = strobe_r;
  assign out_valid_out        = res_r.valid;
  assign out_task_id          = res_r.task_id;
  assign out_state_word       = res_r.state_word;
  assign out_block_number_out = res_r.block_number;
  assign out_elapsed_time     = res_r.elapsed_time;
  assign out_max_elapsed      = res_r.max_elapsed;
  assign out_event_count      = res_r.event_count;
  assign out_stopwatch        = res_r.stopwatch;

  `TTR_ASSERT_NEXT(a_exec_gives_beat, cmd.exec, strobe_r, "exec without result beat")
  `TTR_ASSERT_NEXT(a_beat_single, strobe_r, !strobe_r, "result beat held two cycles")
  `TTR_ASSERT_NOW(a_no_write_clash, cmd.clr_we, !cmd.exec, "sweep and write-back collide")

endmodule

`default_nettype wire

// ===== sv/task_trace_record_table_core.sv =====
// Top level of the task trace record table: controller plus datapath.
// Depends on ttr_pkg, ttr_ctrl and ttr_dpath.
//
// Usage:
//  - Input: drive in_* and raise start; the beat is taken at a rising edge
//    where start is high and busy is low. Fields are sampled only then.
//  - Result: one beat per input, shown for exactly one cycle with out_strobe
//    high. The receiver cannot stall; it must take every beat as it comes.
//  - Result path: the accepting edge captures the fields and reads the entry
//    into a register; in the execute state the record is modified and written
//    back, and the result register and out_strobe are loaded.
//  - Occupancy: a new item is taken only after the execute state of the last,
//    due to the read-modify-write of the entry memory; busy is high in execute.
//  - Reset (rst_n low, synchronous): the controller sweeps the entry memory,
//    one entry per cycle, writing zeros to all 1024 entries with busy high.
//    Items are accepted only after the sweep.
//  - Entries at or beyond the table depth return an all-zero result and
//    leave the memory untouched.
`default_nettype none

module task_trace_record_table_core
  import ttr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic [9:0]  in_entry_index,
  input  wire logic [15:0] in_block_number,
  input  wire logic [31:0] in_state_bits,
  input  wire logic [3:0]  in_nibble_select,
  input  wire logic [31:0] in_timestamp,
  output logic             out_strobe,
  output logic             out_valid_out,
  output logic [9:0]       out_task_id,
  output logic [31:0]      out_state_word,
  output logic [15:0]      out_block_number_out,
  output logic [31:0]      out_elapsed_time,
  output logic [31:0]      out_max_elapsed,
  output logic [31:0]      out_event_count,
  output logic [31:0]      out_stopwatch
);

  // Command bundle from the sequencer to the datapath.
  cmd_t cmd;

  ttr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Entry memory, update logic and result register.
  ttr_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_func              (in_func),
    .in_entry_index       (in_entry_index),
    .in_block_number      (in_block_number),
    .in_state_bits        (in_state_bits),
    .in_nibble_select     (in_nibble_select),
    .in_timestamp         (in_timestamp),
    .out_strobe           (out_strobe),
    .out_valid_out        (out_valid_out),
    .out_task_id          (out_task_id),
    .out_state_word       (out_state_word),
    .out_block_number_out (out_block_number_out),
    .out_elapsed_time     (out_elapsed_time),
    .out_max_elapsed      (out_max_elapsed),
    .out_event_count      (out_event_count),
    .out_stopwatch        (out_stopwatch)
  );

endmodule

`default_nettype wire
